// ----- hw/rtl/nfa_word_acceptance_top_assert.svh -----
// Assertion macros used by the checker of the NFA word acceptor.
`ifndef NFA_WORD_ACCEPTANCE_TOP_ASSERT_SVH
`define NFA_WORD_ACCEPTANCE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define NWA_ASSERT_HOLDS(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define NWA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/nwa_pkg.sv -----
// Shared types, codes and defaults of the NFA word acceptor.
package nwa_pkg;

   localparam int MAX_STATES_DEF = 16;
   localparam int MAX_EDGES_DEF  = 64;

   localparam int STATE_W    = 4;
   localparam int SYM_W      = 8;
   localparam int MASK_W     = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_START  = 2'd1,
      OP_SYMBOL = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_STATE = 1'b0,
      CSR_FINAL_MASK  = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      CTL_IDLE  = 2'b01,
      CTL_SWEEP = 2'b10
   } ctl_state_type;

   // transition being loaded, broadcast to every cell
   typedef struct packed {
      logic               we;
      logic [STATE_W-1:0] source;
      logic [SYM_W-1:0]   label;
      logic [STATE_W-1:0] target;
   } edge_load_type;

endpackage

// ----- hw/rtl/nwa_cell.sv -----
// One transition cell: holds a stored edge and folds its target into the passing set.
module nwa_cell #(
   parameter int MAX_STATES = nwa_pkg::MAX_STATES_DEF,
   parameter int MAX_EDGES  = nwa_pkg::MAX_EDGES_DEF,
   parameter int INDEX      = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  nwa_pkg::edge_load_type        load_i,
   input  logic [$clog2(MAX_EDGES+1)-1:0] count_i,
   input  logic [MAX_STATES-1:0]         live_i,
   input  logic [nwa_pkg::SYM_W-1:0]     sym_i,
   input  logic                          wave_i,
   input  logic [MAX_STATES-1:0]         acc_i,
   output logic                          wave_o,
   output logic [MAX_STATES-1:0]         acc_o
);

   localparam int CntW = $clog2(MAX_EDGES + 1);

   logic [nwa_pkg::STATE_W-1:0] src_ff, tgt_ff;
   logic [nwa_pkg::SYM_W-1:0]   lab_ff;
   logic                        wave_ff, wave_in;
   logic [MAX_STATES-1:0]       acc_ff, acc_in;
   logic [MAX_STATES-1:0]       src_dec, tgt_dec;
   logic                        hit;

   // one-hot decode; indexes past the state count decode to nothing
   always_comb begin
      for (int k = 0; k < MAX_STATES; k++) begin
         src_dec[k] = (32'(src_ff) == k);
         tgt_dec[k] = (32'(tgt_ff) == k);
      end
   end

   assign hit     = (CntW'(INDEX) < count_i) && (lab_ff == sym_i) && ((live_i & src_dec) != '0);
   assign acc_in  = acc_i | (hit ? tgt_dec : '0);
   assign wave_in = wave_i;

   always_ff @(posedge clock) begin
      if (load_i.we && (count_i == CntW'(INDEX))) begin
         src_ff <= load_i.source;
         lab_ff <= load_i.label;
         tgt_ff <= load_i.target;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_ff <= 1'b0;
      end else begin
         wave_ff <= wave_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign wave_o = wave_ff;
   assign acc_o  = acc_ff;

endmodule

// ----- hw/rtl/nfa_word_acceptance_top.sv -----
// NFA word acceptor: control, live set, settings and the row of transition cells.
// Add, start and clear words: rsp_valid pulses in the cycle right after the accepting edge.
// Symbol words: the wave bit passes launch_ff and each cell's register, then rsp_valid pulses;
//   the new set ripples through the MAX_EDGES cells one per cycle; busy stays high until then.
// A new word is taken in the cycle the previous result shows; the receiver cannot stall.
// Reset clears the live set, edge count, start_state and final_mask; stored edges are kept.
module nfa_word_acceptance_top #(
   parameter int MAX_STATES = nwa_pkg::MAX_STATES_DEF,
   parameter int MAX_EDGES  = nwa_pkg::MAX_EDGES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // word input
   input  logic                             start,
   output logic                             busy,
   input  logic [1:0]                       req_op,
   input  logic [nwa_pkg::STATE_W-1:0]      req_from_state,
   input  logic [nwa_pkg::SYM_W-1:0]        req_symbol,
   input  logic [nwa_pkg::STATE_W-1:0]      req_to_state,
   // result output
   output logic                             rsp_valid,
   output logic                             rsp_accepted,
   output logic                             rsp_no_live_path,
   output logic                             rsp_table_full,
   // settings write port
   input  logic                             csr_we,
   input  logic [nwa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [nwa_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int CntW  = $clog2(MAX_EDGES + 1);
   localparam int WideW = MAX_STATES + nwa_pkg::MASK_W;

   nwa_pkg::ctl_state_type state_ff, state_in;
   logic [CntW-1:0]               count_ff, count_in;
   logic [MAX_STATES-1:0]         active_ff, active_in;
   logic [nwa_pkg::STATE_W-1:0]   start_ff;
   logic [nwa_pkg::MASK_W-1:0]    mask_ff;
   logic [nwa_pkg::SYM_W-1:0]     sym_ff, sym_in;
   logic                          launch_ff, launch_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_accepted_ff, rsp_accepted_in;
   logic                          rsp_no_live_ff, rsp_no_live_in;
   logic                          rsp_full_ff, rsp_full_in;

   logic                          accept;
   logic                          go_sweep;
   logic                          table_full;
   nwa_pkg::op_type               op;
   nwa_pkg::edge_load_type        load;
   logic [MAX_STATES-1:0]         start_dec;
   logic [WideW-1:0]              mask_wide;
   logic [MAX_STATES-1:0]         mask_eff;

   // cell chain links: index 0 feeds the first cell, the last one is the tail
   logic                          wave_w [MAX_EDGES+1];
   logic [MAX_STATES-1:0]         acc_w  [MAX_EDGES+1];

   assign op         = nwa_pkg::op_type'(req_op);
   assign busy       = (state_ff == nwa_pkg::CTL_SWEEP);
   assign accept     = start && !busy;
   assign go_sweep   = accept && (op == nwa_pkg::OP_SYMBOL);
   assign table_full = (count_ff == CntW'(MAX_EDGES));

   // final_mask bits past the state count are ignored
   assign mask_wide = WideW'(mask_ff);
   assign mask_eff  = mask_wide[MAX_STATES-1:0];

   // start state as a one-hot set; empty when the index names no state
   always_comb begin
      for (int k = 0; k < MAX_STATES; k++) begin
         start_dec[k] = (32'(start_ff) == k);
      end
   end

   // new edge goes into the cell whose index equals the current count
   always_comb begin
      load.we     = accept && (op == nwa_pkg::OP_ADD) && !table_full;
      load.source = req_from_state;
      load.label  = req_symbol;
      load.target = req_to_state;
   end

   // ---- transition cells ----
   // The symbol and live set stay put during a sweep; a wave bit walks the row,
   // each cell ORs in its target when its edge fires, and the tail holds the new set.
   assign wave_w[0] = launch_ff;
   assign acc_w[0]  = '0;

   for (genvar i = 0; i < MAX_EDGES; i++) begin : g_cell
      nwa_cell #(
         .MAX_STATES (MAX_STATES),
         .MAX_EDGES  (MAX_EDGES),
         .INDEX      (i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .load_i  (load),
         .count_i (count_ff),
         .live_i  (active_ff),
         .sym_i   (sym_ff),
         .wave_i  (wave_w[i]),
         .acc_i   (acc_w[i]),
         .wave_o  (wave_w[i+1]),
         .acc_o   (acc_w[i+1])
      );
   end

   // ---- control ----
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         nwa_pkg::CTL_IDLE: begin
            if (go_sweep) state_in = nwa_pkg::CTL_SWEEP;
         end
         nwa_pkg::CTL_SWEEP: begin
            if (wave_w[MAX_EDGES]) state_in = nwa_pkg::CTL_IDLE;
         end
         default: state_in = nwa_pkg::CTL_IDLE;
      endcase
   end

   assign launch_in = go_sweep;
   assign sym_in    = go_sweep ? req_symbol : sym_ff;

   // live set, edge count and the result word
   always_comb begin
      active_in    = active_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_full_in  = 1'b0;
      if (accept) begin
         unique case (op)
            nwa_pkg::OP_ADD: begin
               rsp_valid_in = 1'b1;
               rsp_full_in  = table_full;
               if (!table_full) count_in = count_ff + CntW'(1);
            end
            nwa_pkg::OP_START: begin
               rsp_valid_in = 1'b1;
               active_in    = start_dec;
            end
            nwa_pkg::OP_SYMBOL: begin
               // result comes from the tail of the row
            end
            nwa_pkg::OP_CLEAR: begin
               rsp_valid_in = 1'b1;
               count_in     = '0;
            end
         endcase
      end else if (busy && wave_w[MAX_EDGES]) begin
         rsp_valid_in = 1'b1;
         active_in    = acc_w[MAX_EDGES];
      end
      rsp_accepted_in = ((active_in & mask_eff) != '0);
      rsp_no_live_in  = (active_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nwa_pkg::CTL_IDLE;
         count_ff     <= '0;
         active_ff    <= '0;
         start_ff     <= '0;
         mask_ff      <= '0;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         active_ff    <= active_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (nwa_pkg::csr_index_type'(csr_index))
               nwa_pkg::CSR_START_STATE: start_ff <= csr_wdata[nwa_pkg::STATE_W-1:0];
               nwa_pkg::CSR_FINAL_MASK:  mask_ff  <= csr_wdata[nwa_pkg::MASK_W-1:0];
            endcase
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      sym_ff          <= sym_in;
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_no_live_ff  <= rsp_no_live_in;
      rsp_full_ff     <= rsp_full_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accepted     = rsp_accepted_ff;
   assign rsp_no_live_path = rsp_no_live_ff;
   assign rsp_table_full   = rsp_full_ff;

endmodule

// ----- hw/rtl/nwa_checker.sv -----
// Port-level checker of the NFA word acceptor, bound to the top level.
`include "nfa_word_acceptance_top_assert.svh"

module nwa_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [1:0] req_op,
   input logic       rsp_valid,
   input logic       rsp_accepted,
   input logic       rsp_no_live_path,
   input logic       rsp_table_full
);

   logic take_quick, take_symbol;

   assign take_quick  = start && !busy && (req_op != nwa_pkg::OP_SYMBOL);
   assign take_symbol = start && !busy && (req_op == nwa_pkg::OP_SYMBOL);

   `NWA_ASSERT_NEXT(a_quick_result, take_quick, rsp_valid, "add/start/clear word gave no result")
   `NWA_ASSERT_NEXT(a_sweep_starts, take_symbol, busy && !rsp_valid, "symbol word did not sweep")
   `NWA_ASSERT_HOLDS(a_sweep_ends, $fell(busy) && !$past(reset), rsp_valid, "sweep ended without result")
   `NWA_ASSERT_HOLDS(a_full_on_add, rsp_valid && rsp_table_full,
                     $past(start && !busy && req_op == nwa_pkg::OP_ADD), "table_full on non-add word")

endmodule

bind nfa_word_acceptance_top nwa_checker u_nwa_checker (.*);
